### design/rhc_pkg.sv
// Shared types and constants of the RGB to HSL converter.
package rhc_pkg;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SUM_W  = 9;
  localparam int QH_W   = 12;
  localparam int QS_W   = 8;
  localparam int NH_W   = QH_W + CHAN_W;
  localparam int NS_W   = QS_W + CHAN_W;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [SUM_W-1:0]  SUM_HALF   = 9'd255;
  localparam logic [SUM_W-1:0]  SUM_FULL   = 9'd510;
  localparam logic [HUE_W-1:0]  HUE_GREEN  = 15'd7680;
  localparam logic [HUE_W-1:0]  HUE_BLUE   = 15'd15360;
  localparam logic [HUE_W-1:0]  HUE_TURN   = 15'd23040;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic              grey;
    logic              neg;
    sector_t           sector;
    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] alpha;
  } side_t;

endpackage

### design/rhc_divider.sv
// Pipelined restoring divider, one hue and up to one saturation quotient bit per stage.
module rhc_divider
  import rhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NH_W-1:0]   num_hue,
  input  logic [CHAN_W-1:0] den_hue,
  input  logic [NS_W-1:0]   num_sat,
  input  logic [CHAN_W-1:0] den_sat,
  input  side_t             side_in,
  output logic              out_valid,
  output logic [QH_W-1:0]   quo_hue,
  output logic [QS_W-1:0]   quo_sat,
  output side_t             side_out
);

  function automatic logic [CHAN_W+QH_W-1:0] step_h(logic [CHAN_W-1:0] rem,
                                                    logic [QH_W-1:0] work,
                                                    logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] diff;
    t = {rem, work[QH_W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[CHAN_W-1:0], work[QH_W-2:0], 1'b1};
    end
    return {t[CHAN_W-1:0], work[QH_W-2:0], 1'b0};
  endfunction

  function automatic logic [CHAN_W+QS_W-1:0] step_s(logic [CHAN_W-1:0] rem,
                                                    logic [QS_W-1:0] work,
                                                    logic [CHAN_W-1:0] d);
    logic [CHAN_W:0] t;
    logic [CHAN_W:0] diff;
    t = {rem, work[QS_W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[CHAN_W-1:0], work[QS_W-2:0], 1'b1};
    end
    return {t[CHAN_W-1:0], work[QS_W-2:0], 1'b0};
  endfunction

  logic              valid [QH_W];
  logic [CHAN_W-1:0] rem_h [QH_W];
  logic [QH_W-1:0]   work_h[QH_W];
  logic [CHAN_W-1:0] d_h   [QH_W];
  logic [CHAN_W-1:0] rem_s [QH_W];
  logic [QS_W-1:0]   work_s[QH_W];
  logic [CHAN_W-1:0] d_s   [QH_W];
  side_t             side  [QH_W];

  for (genvar k = 0; k < QH_W; k++) begin : g_stage
    logic              v_src;
    logic [CHAN_W-1:0] rh_src;
    logic [QH_W-1:0]   wh_src;
    logic [CHAN_W-1:0] dh_src;
    logic [CHAN_W-1:0] rs_src;
    logic [QS_W-1:0]   ws_src;
    logic [CHAN_W-1:0] ds_src;
    side_t             side_src;

    if (k == 0) begin : g_first
      assign v_src    = in_valid;
      assign rh_src   = num_hue[NH_W-1:QH_W];
      assign wh_src   = num_hue[QH_W-1:0];
      assign dh_src   = den_hue;
      assign rs_src   = num_sat[NS_W-1:QS_W];
      assign ws_src   = num_sat[QS_W-1:0];
      assign ds_src   = den_sat;
      assign side_src = side_in;
    end else begin : g_next
      assign v_src    = valid[k-1];
      assign rh_src   = rem_h[k-1];
      assign wh_src   = work_h[k-1];
      assign dh_src   = d_h[k-1];
      assign rs_src   = rem_s[k-1];
      assign ws_src   = work_s[k-1];
      assign ds_src   = d_s[k-1];
      assign side_src = side[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        {rem_h[k], work_h[k]} <= step_h(rh_src, wh_src, dh_src);
        d_h[k]  <= dh_src;
        d_s[k]  <= ds_src;
        side[k] <= side_src;
        if (k < QS_W) begin
          {rem_s[k], work_s[k]} <= step_s(rs_src, ws_src, ds_src);
        end else begin
          rem_s[k]  <= rs_src;
          work_s[k] <= ws_src;
        end
      end
    end
  end

  assign out_valid = valid[QH_W-1];
  assign quo_hue   = work_h[QH_W-1];
  assign quo_sat   = work_s[QH_W-1];
  assign side_out  = side[QH_W-1];

endmodule

### design/rgb_to_hsl_convert_top.sv
// Top level of the RGB to HSL pixel converter.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_ready  | red, green, blue, alpha
//  out     | output    | out_valid / out_ready| hue, saturation, lightness_sum, alpha_out
//
// One pixel per cycle unless the output word is held; the pipe is two front stages, a
// twelve-stage divider taking one quotient bit per stage, and the output register.
// Reset clears every valid bit; payload registers are left as they are.
// The whole pipeline holds while the output word waits, so in_ready is
// low only when out_valid is high and out_ready is low.
module rgb_to_hsl_convert_top
  import rhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic [CHAN_W-1:0] alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HUE_W-1:0]  hue,
  output logic [CHAN_W-1:0] saturation,
  output logic [SUM_W-1:0]  lightness_sum,
  output logic [CHAN_W-1:0] alpha_out
);

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [CHAN_W-1:0] hi_c, lo_c, rg_max, rg_min, mag_c;
  logic [SUM_W-1:0]  sum_c, diff_c, neg_diff_c;
  sector_t           sector_c;

  always_comb begin
    rg_max = (red >= green) ? red : green;
    rg_min = (red <= green) ? red : green;
    hi_c   = (rg_max >= blue) ? rg_max : blue;
    lo_c   = (rg_min <= blue) ? rg_min : blue;
    sum_c  = {1'b0, hi_c} + {1'b0, lo_c};
    if (red >= hi_c) begin
      sector_c = SECTOR_RED;
      diff_c   = {1'b0, green} - {1'b0, blue};
    end else if (green >= hi_c) begin
      sector_c = SECTOR_GREEN;
      diff_c   = {1'b0, blue} - {1'b0, red};
    end else begin
      sector_c = SECTOR_BLUE;
      diff_c   = {1'b0, red} - {1'b0, green};
    end
    neg_diff_c = '0 - diff_c;
    mag_c      = diff_c[SUM_W-1] ? neg_diff_c[CHAN_W-1:0] : diff_c[CHAN_W-1:0];
  end

  logic              v1;
  logic [CHAN_W-1:0] delta1, mag1;
  side_t             side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta1       <= hi_c - lo_c;
      mag1         <= mag_c;
      side1.grey   <= (hi_c == lo_c);
      side1.neg    <= diff_c[SUM_W-1];
      side1.sector <= sector_c;
      side1.sum    <= sum_c;
      side1.alpha  <= alpha;
    end
  end

  logic [SUM_W-1:0]  far_c;
  logic [CHAN_W-1:0] den_c;

  always_comb begin
    far_c = SUM_FULL - side1.sum;
    den_c = (side1.sum <= SUM_HALF) ? side1.sum[CHAN_W-1:0] : far_c[CHAN_W-1:0];
  end

  logic              v2;
  logic [NH_W-1:0]   num_h2;
  logic [NS_W-1:0]   num_s2;
  logic [CHAN_W-1:0] den_h2, den_s2;
  side_t             side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_h2 <= {mag1, {QH_W{1'b0}}} - {{(NH_W-CHAN_W-8){1'b0}}, mag1, 8'd0};
      num_s2 <= {delta1, {QS_W{1'b0}}} - {{QS_W{1'b0}}, delta1};
      den_h2 <= delta1;
      den_s2 <= den_c;
      side2  <= side1;
    end
  end

  logic              dv;
  logic [QH_W-1:0]   quo_h;
  logic [QS_W-1:0]   quo_s;
  side_t             side_d;

  rhc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num_hue  (num_h2),
    .den_hue  (den_h2),
    .num_sat  (num_s2),
    .den_sat  (den_s2),
    .side_in  (side2),
    .out_valid(dv),
    .quo_hue  (quo_h),
    .quo_sat  (quo_s),
    .side_out (side_d)
  );

  logic [HUE_W-1:0] q15, base_c, hue_c;

  always_comb begin
    q15 = {{(HUE_W-QH_W){1'b0}}, quo_h};
    case (side_d.sector)
      SECTOR_GREEN: base_c = HUE_GREEN;
      SECTOR_BLUE:  base_c = HUE_BLUE;
      default:      base_c = side_d.neg ? HUE_TURN : '0;
    endcase
    if (side_d.grey) begin
      hue_c = '0;
    end else if (side_d.neg) begin
      hue_c = base_c - q15;
    end else begin
      hue_c = base_c + q15;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue           <= hue_c;
      saturation    <= side_d.grey ? '0 : quo_s;
      lightness_sum <= side_d.sum;
      alpha_out     <= side_d.alpha;
    end
  end

`ifndef SYNTH
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output word is held");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HUE_TURN))
    else $error("hue out of range");

  a_extreme_grey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (lightness_sum == '0 || lightness_sum == SUM_FULL))
      |-> (hue == '0 && saturation == '0))
    else $error("black or white pixel with hue or saturation");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (dv && out_valid && out_ready) |=> out_valid)
    else $error("finished word lost between divider and output");
`endif

endmodule
